/* hdl/equal_mass_range_binner_defines.svh */
// ---------------------------------------------------------------------------
// equal mass range binner assertion macros
// shared concurrent assertion forms used by the binner rtl
// ---------------------------------------------------------------------------
`ifndef EQUAL_MASS_RANGE_BINNER_DEFINES_SVH
`define EQUAL_MASS_RANGE_BINNER_DEFINES_SVH

// same-cycle implication
`define EMRB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EMRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/emrb_pkg.sv */
// ---------------------------------------------------------------------------
// emrb_pkg
// word types, csr indexes and fixed field widths of the range binner
// ---------------------------------------------------------------------------
package emrb_pkg;

   localparam int RUN_W   = 32;
   localparam int BCNT_W  = 13;
   localparam int BIDX_W  = 12;
   localparam int PAD_W   = 13;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BINS   = 1'b0,
      CSR_TOTAL_ROWS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [RUN_W-1:0] run_length;
      logic             last_run;
   } req_word_type;

   typedef struct packed {
      logic [BIDX_W-1:0] bin_index;
      logic              opens_bin;
      logic [PAD_W-1:0]  pad_count;
      logic              last_result;
   } rsp_word_type;

   typedef struct packed {
      logic [BCNT_W-1:0] num_bins;
      logic [RUN_W-1:0]  total_rows;
   } cfg_type;

endpackage

/* hdl/emrb_csr.sv */
// ---------------------------------------------------------------------------
// emrb_csr
// configuration registers of the range binner, written over the csr channel
// ---------------------------------------------------------------------------
module emrb_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  emrb_pkg::csr_index_type    csr_index,
   input  logic [emrb_pkg::RUN_W-1:0] csr_wdata,
   output emrb_pkg::cfg_type          cfg
);
   import emrb_pkg::*;

   logic [BCNT_W-1:0] num_bins_ff, num_bins_in;
   logic [RUN_W-1:0]  total_rows_ff, total_rows_in;

   assign csr_ready = 1'b1;

   always_comb begin
      num_bins_in   = num_bins_ff;
      total_rows_in = total_rows_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_BINS:   num_bins_in   = csr_wdata[BCNT_W-1:0];
            CSR_TOTAL_ROWS: total_rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bins_ff   <= BCNT_W'(1);
         total_rows_ff <= '0;
      end else begin
         num_bins_ff   <= num_bins_in;
         total_rows_ff <= total_rows_in;
      end
   end

   assign cfg.num_bins   = num_bins_ff;
   assign cfg.total_rows = total_rows_ff;

endmodule

/* hdl/emrb_core.sv */
// ---------------------------------------------------------------------------
// emrb_core
// per-run close decision and binning state, one run per step
// ---------------------------------------------------------------------------
`include "equal_mass_range_binner_defines.svh"

module emrb_core #(
   parameter int MAX_BINS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  emrb_pkg::req_word_type req_word,
   input  emrb_pkg::cfg_type     cfg,
   output emrb_pkg::rsp_word_type rsp_word
);
   import emrb_pkg::*;

   // bins_left never exceeds the clamped bin count
   localparam int MB_W = $clog2(MAX_BINS + 1);
   localparam int BL_W = (MB_W < BCNT_W) ? MB_W : BCNT_W;
   localparam int PW   = RUN_W + BL_W;

   logic [RUN_W-1:0]  open_mass_ff, open_mass_in;
   logic [RUN_W-1:0]  mass_left_ff, mass_left_in;
   logic [BL_W-1:0]   bins_left_ff, bins_left_in;
   logic [BIDX_W-1:0] closes_ff, closes_in;
   logic              fresh_ff, fresh_in;

   logic [BL_W-1:0]   bl_eff, cur_bl, bins_after;
   logic [RUN_W-1:0]  cur_m, cur_mass, mass_after, base_mass;
   logic [BIDX_W-1:0] cur_closes, closes_after;
   logic [PW-1:0]     p_run, p_cur;
   logic [PW:0]       p_sum, m_ext, d_cur, d_sum;
   logic [RUN_W:0]    open_sum;
   logic [BCNT_W-1:0] bins_after_w;
   logic              can_close, own_bin, closer_now, do_close;

   always_comb begin
      if (cfg.num_bins == '0) begin
         bl_eff = BL_W'(1);
      end else if (32'(cfg.num_bins) > 32'(MAX_BINS)) begin
         bl_eff = BL_W'(MAX_BINS);
      end else begin
         bl_eff = BL_W'(cfg.num_bins);
      end
   end

   // first run of an attribute starts from the configured values
   assign cur_bl     = fresh_ff ? bl_eff : bins_left_ff;
   assign cur_m      = fresh_ff ? cfg.total_rows : mass_left_ff;
   assign cur_mass   = fresh_ff ? '0 : open_mass_ff;
   assign cur_closes = fresh_ff ? '0 : closes_ff;

   assign can_close = (cur_mass != '0) && (cur_bl > BL_W'(1));

   // exact cross products against the remaining mass
   assign p_run = PW'(req_word.run_length) * PW'(cur_bl);
   assign p_cur = PW'(cur_mass) * PW'(cur_bl);
   assign p_sum = {1'b0, p_cur} + {1'b0, p_run};
   assign m_ext = (PW+1)'(cur_m);

   assign own_bin = {1'b0, p_run} >= m_ext;
   assign d_cur   = ({1'b0, p_cur} >= m_ext) ? {1'b0, p_cur} - m_ext : m_ext - {1'b0, p_cur};
   assign d_sum   = (p_sum >= m_ext) ? p_sum - m_ext : m_ext - p_sum;
   assign closer_now = d_cur <= d_sum;
   assign do_close = can_close && (own_bin || closer_now);

   always_comb begin
      if (do_close) begin
         mass_after   = (cur_m >= cur_mass) ? cur_m - cur_mass : '0;
         bins_after   = cur_bl - BL_W'(1);
         closes_after = cur_closes + BIDX_W'(1);
         base_mass    = '0;
      end else begin
         mass_after   = cur_m;
         bins_after   = cur_bl;
         closes_after = cur_closes;
         base_mass    = cur_mass;
      end
   end

   // open bin mass saturates
   assign open_sum     = {1'b0, base_mass} + {1'b0, req_word.run_length};
   assign open_mass_in = open_sum[RUN_W] ? '1 : open_sum[RUN_W-1:0];
   assign mass_left_in = mass_after;
   assign bins_left_in = bins_after;
   assign closes_in    = closes_after;
   assign fresh_in     = req_word.last_run;
   assign bins_after_w = BCNT_W'(bins_after);

   always_comb begin
      rsp_word.opens_bin   = fresh_ff || do_close;
      rsp_word.last_result = req_word.last_run;
      if (req_word.last_run) begin
         rsp_word.bin_index = closes_after + bins_after_w[BIDX_W-1:0] - BIDX_W'(1);
         rsp_word.pad_count = PAD_W'(bins_after_w);
      end else begin
         rsp_word.bin_index = closes_after;
         rsp_word.pad_count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_mass_ff <= '0;
         mass_left_ff <= '0;
         bins_left_ff <= '0;
         closes_ff    <= '0;
         fresh_ff     <= 1'b1;
      end else if (step) begin
         open_mass_ff <= open_mass_in;
         mass_left_ff <= mass_left_in;
         bins_left_ff <= bins_left_in;
         closes_ff    <= closes_in;
         fresh_ff     <= fresh_in;
      end
   end

   `EMRB_ASSERT_NEXT(a_last_rearms, clock, reset, step && req_word.last_run, fresh_ff,
                     "last run did not rearm attribute start")
   `EMRB_ASSERT_NOW(a_bins_nonzero, clock, reset, !fresh_ff, bins_left_ff != '0,
                    "bins left reached zero mid attribute")
   `EMRB_ASSERT_NOW(a_first_opens, clock, reset, step && fresh_ff, rsp_word.opens_bin,
                    "first run of attribute did not open a bin")

endmodule

/* hdl/equal_mass_range_binner.sv */
// ---------------------------------------------------------------------------
// equal_mass_range_binner
// equal-depth binning of sorted runs into near-equal row mass bins
// ---------------------------------------------------------------------------
// Runs of equal values arrive one word per cycle in ascending value order, and
// each run gets exactly one result word: its bin, whether it opens a bin, and
// on the final run of an attribute the count of padding thresholds. Throughput
// is one run per clock with no bubbles while rsp_stall is low; an accepted run
// passes the input register, then the result register, before its result
// shows on rsp_valid. The rate is set by the per-run recurrence in the core:
// two 32 x 13 bit cross products, their compares against the remaining mass
// and the state update all complete combinationally between the two registers.
// The bin count and total_rows are sampled when the first run of an attribute
// is processed, so write them only while the block is idle between attributes.
module equal_mass_range_binner #(
   parameter int MAX_BINS = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   // run words
   input  logic                       req_valid,
   output logic                       req_stall,
   input  emrb_pkg::req_word_type     req_word,
   // result words
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output emrb_pkg::rsp_word_type     rsp_word,
   // configuration writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  emrb_pkg::csr_index_type    csr_index,
   input  logic [emrb_pkg::RUN_W-1:0] csr_wdata
);
   import emrb_pkg::*;

   cfg_type      cfg;
   req_word_type in_word_ff;
   rsp_word_type out_word_ff, core_word;
   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic         out_free, step, accept;

   // result register can take a word when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   // a run moves from input to result register, updating binning state
   assign step      = in_valid_ff && out_free;
   // input register is busy only when it holds a word that cannot move
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (step) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (step) begin
         out_word_ff <= core_word;
      end
   end

   emrb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // close decision and bin bookkeeping
   emrb_core #(
      .MAX_BINS (MAX_BINS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_word (in_word_ff),
      .cfg      (cfg),
      .rsp_word (core_word)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

/* test/equal_mass_range_binner_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// equal_mass_range_binner_test
// self-checking bench for the equal-mass range binner
// ---------------------------------------------------------------------------
// A table of directed run words covers the register extremes, the bin count
// clamps, mass saturation, zero-length and single-run attributes and a
// register write in the middle of an attribute. Random attributes follow,
// mostly with a total mass that matches their runs. Every result word is
// checked against a word from the table or a bench-side model of the binning
// recurrence, with random gaps on the run side, random stalls on the result
// side and one long result stall that backs the pipeline up.
module equal_mass_range_binner_test;
   import emrb_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int MAX_BINS       = 4096;
   localparam int RESET_CYCLES   = 4;
   localparam int DRAIN_CYCLES   = 4;    // pipeline is two registers deep
   localparam int LONG_HOLD      = 96;
   localparam int RANDOM_RUNS    = 1500;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic {ROW_RUN, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type idx;
      logic [31:0]   value;     // run length or register data
      logic          last;
      bit            typed;     // expected word given in the table
      rsp_word_type  want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_word_type  req_word = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_word_type  rsp_word;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_NUM_BINS;
   logic [31:0]   csr_wdata = '0;

   // bench copy of the registers and of the binning state
   logic [12:0]   cfg_num_bins   = 13'd1;
   logic [31:0]   cfg_total_rows = '0;
   logic [31:0]   open_mass      = '0;
   logic [31:0]   mass_left      = '0;
   logic [12:0]   bins_left      = '0;
   logic [11:0]   closes_done    = '0;
   logic          fresh_attr     = 1'b1;

   rsp_word_type  pending_bins[$];
   int            mismatches = 0;
   int            quiet_cycles = 0;
   bit            hold_request = 1'b0;
   int            phase_left = 0;

   equal_mass_range_binner #(.MAX_BINS(MAX_BINS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mostly no gap, sometimes a few cycles, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // run lengths: some zero, mostly moderate, a few spanning the full 32 bits
   function automatic logic [31:0] pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return '0;
      if (r < 75) return $urandom_range(1, 2000);
      if (r < 93) return $urandom_range(1, 1 << 20);
      return $urandom;
   endfunction

   // binning recurrence for one accepted run word; updates the bench state
   function automatic rsp_word_type place_run(input req_word_type w);
      rsp_word_type r;
      logic [63:0]  run, bl, m, now_prod, then_prod, dist_now, dist_then, total;
      logic [12:0]  eff_bins;
      logic [13:0]  final_bin;
      logic         opens;
      run   = 64'(w.run_length);
      opens = 1'b0;
      // first run of an attribute samples the registers
      if (fresh_attr) begin
         eff_bins = cfg_num_bins;
         if (eff_bins == 0) eff_bins = 13'd1;
         if (eff_bins > MAX_BINS) eff_bins = 13'(MAX_BINS);
         bins_left   = eff_bins;
         mass_left   = cfg_total_rows;
         open_mass   = '0;
         closes_done = '0;
         fresh_attr  = 1'b0;
         opens       = 1'b1;
      end
      // close the open bin before this run if it is non-empty, a later bin
      // exists, and the run fills a bin alone or closing now lands nearer
      if (open_mass != 0 && bins_left > 1) begin
         bl        = 64'(bins_left);
         m         = 64'(mass_left);
         now_prod  = 64'(open_mass) * bl;
         then_prod = (64'(open_mass) + run) * bl;
         dist_now  = (now_prod >= m) ? now_prod - m : m - now_prod;
         dist_then = (then_prod >= m) ? then_prod - m : m - then_prod;
         if (run * bl >= m || dist_now <= dist_then) begin
            mass_left   = (mass_left >= open_mass) ? mass_left - open_mass : '0;
            bins_left   = bins_left - 13'd1;
            closes_done = closes_done + 12'd1;
            open_mass   = '0;
            opens       = 1'b1;
         end
      end
      total     = 64'(open_mass) + run;
      open_mass = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      if (w.last_run) begin
         final_bin     = 14'(closes_done) + 14'(bins_left) - 14'd1;
         r.bin_index   = final_bin[11:0];
         r.pad_count   = bins_left;
         fresh_attr    = 1'b1;
      end else begin
         r.bin_index   = closes_done;
         r.pad_count   = '0;
      end
      r.opens_bin   = opens;
      r.last_result = w.last_run;
      return r;
   endfunction

   function automatic stim_row_type run_row(input logic [31:0] len, input logic last);
      stim_row_type row;
      row.kind  = ROW_RUN;
      row.idx   = CSR_NUM_BINS;
      row.value = len;
      row.last  = last;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [31:0] len, input logic last,
                                              input logic [11:0] bin, input logic opens,
                                              input logic [12:0] pad);
      stim_row_type row;
      row = run_row(len, last);
      row.typed            = 1'b1;
      row.want.bin_index   = bin;
      row.want.opens_bin   = opens;
      row.want.pad_count   = pad;
      row.want.last_result = last;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(input csr_index_type idx, input logic [31:0] val);
      stim_row_type row;
      row       = run_row(val, 1'b0);
      row.kind  = ROW_CFG;
      row.idx   = idx;
      return row;
   endfunction

   // offer one run word, hold it until taken, then queue its expected result
   task automatic offer_run(input logic [31:0] len, input logic last, input int gap,
                            input bit use_want, input rsp_word_type want);
      req_word_type w;
      rsp_word_type placed;
      w.run_length = len;
      w.last_run   = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      placed = place_run(w);
      pending_bins.insert(pending_bins.size(), use_want ? want : placed);
   endtask

   // stop offering and wait until every result word is back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_NUM_BINS) cfg_num_bins = val[12:0];
      else                     cfg_total_rows = val;
   endtask

   // run side stimulus
   initial begin : stimulus
      stim_row_type directed[$];
      stim_row_type row;
      logic [31:0]  lens[$];
      logic [31:0]  mass_sum, bin_word, total_word;
      int           runs_sent, attr, n_runs, r;
      bit           burst, forced;

      // after reset: one bin, zero mass
      directed = {directed, known_row(32'd5, 1'b1, 12'd0, 1'b1, 13'd1)};
      // bin count zero acts as one; zero-length single run
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd0)};
      directed = {directed, known_row(32'd0, 1'b1, 12'd0, 1'b1, 13'd1)};
      // bin count above the maximum clamps; largest run and mass
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd8191)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'hFFFF_FFFF)};
      directed = {directed, known_row(32'hFFFF_FFFF, 1'b1, 12'd4095, 1'b1, 13'd4096)};
      // exactly the maximum bin count
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd4096)};
      directed = {directed, known_row(32'd1, 1'b1, 12'd4095, 1'b1, 13'd4096)};
      // one bin: the open bin mass saturates without any close
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd1)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'd0)};
      directed = {directed, known_row(32'hFFFF_FFFF, 1'b0, 12'd0, 1'b1, 13'd0)};
      directed = {directed, known_row(32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0, 13'd0)};
      directed = {directed, known_row(32'hFFFF_FFFF, 1'b1, 12'd0, 1'b0, 13'd1)};
      // runs far above the stated mass: remaining mass floors at zero
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd4)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'd10)};
      directed = {directed, run_row(32'd100, 1'b0)};
      directed = {directed, run_row(32'd100, 1'b0)};
      directed = {directed, run_row(32'd100, 1'b0)};
      directed = {directed, run_row(32'd5, 1'b1)};
      // close decided by nearness alone, the run being under the target
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd2)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'd20)};
      directed = {directed, run_row(32'd9, 1'b0)};
      directed = {directed, run_row(32'd3, 1'b0)};
      directed = {directed, run_row(32'd8, 1'b1)};
      // leading zero-length runs keep the first bin empty
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd3)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'd30)};
      directed = {directed, run_row(32'd0, 1'b0)};
      directed = {directed, run_row(32'd0, 1'b0)};
      directed = {directed, run_row(32'd12, 1'b0)};
      directed = {directed, run_row(32'd18, 1'b1)};
      // register writes mid-attribute apply from the next attribute on
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd2)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'd20)};
      directed = {directed, run_row(32'd10, 1'b0)};
      directed = {directed, cfg_row(CSR_NUM_BINS, 32'd5)};
      directed = {directed, cfg_row(CSR_TOTAL_ROWS, 32'd50)};
      directed = {directed, run_row(32'd10, 1'b1)};
      directed = {directed, known_row(32'd10, 1'b1, 12'd4, 1'b1, 13'd5)};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < directed.size(); i++) begin
         row = directed[i];
         if (row.kind == ROW_CFG) begin
            // registers only change with the pipeline empty
            if (i == 0 || directed[i-1].kind != ROW_CFG) settle();
            csr_write(row.idx, row.value);
            if (i + 1 == directed.size() || directed[i+1].kind != ROW_CFG)
               csr_valid <= 1'b0;
         end else begin
            offer_run(row.value, row.last, pick_gap(), row.typed, row.want);
         end
      end

      // random attributes
      runs_sent = 0;
      attr = 0;
      while (runs_sent < RANDOM_RUNS) begin
         forced = (attr == 3);
         r = $urandom_range(0, 99);
         if (forced)      n_runs = 60;
         else if (r < 10) n_runs = 1;
         else if (r < 85) n_runs = $urandom_range(2, 24);
         else             n_runs = $urandom_range(25, 80);
         lens.delete();
         mass_sum = '0;
         for (int k = 0; k < n_runs; k++) begin
            lens.insert(lens.size(), pick_run_length());
            mass_sum = mass_sum + lens[k];
         end

         // new registers for most attributes, the rest reuse the old ones
         if (attr == 0 || forced || $urandom_range(0, 9) < 7) begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 60)      bin_word = $urandom_range(1, 16);
            else if (r < 80) bin_word = $urandom_range(17, 300);
            else if (r < 88) bin_word = $urandom_range(4000, 4096);
            else if (r < 94) bin_word = $urandom_range(4097, 8191);
            else             bin_word = '0;
            // upper data bits are not part of the bin count
            if ($urandom_range(0, 3) == 0) bin_word[31:13] = 19'($urandom);
            r = $urandom_range(0, 99);
            if (r < 80)      total_word = mass_sum;
            else if (r < 90) total_word = $urandom;
            else             total_word = $urandom_range(0, 100);
            csr_write(CSR_NUM_BINS, bin_word);
            csr_write(CSR_TOTAL_ROWS, total_word);
            csr_valid <= 1'b0;
         end

         // the long result stall lands on a back-to-back attribute
         burst = forced || ($urandom_range(0, 3) == 0);
         if (forced) hold_request = 1'b1;
         for (int k = 0; k < n_runs; k++) begin
            offer_run(lens[k], k == n_runs - 1, burst ? 0 : pick_gap(), 1'b0, '0);
            runs_sent++;
         end
         attr++;
      end

      req_valid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else                 $display("*** FAILED ***");
      $finish;
   end

   // result side stall pattern, with one long hold on request
   always @(posedge clock) begin : stall_pattern
      int len;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         rsp_stall <= 1'b1;
         phase_left = LONG_HOLD - 1;
      end else if (phase_left != 0) begin
         phase_left = phase_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         // mostly short free spells, sometimes a long one with no stalls
         phase_left = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 5);
      end else begin
         len = pick_gap();
         if (len != 0) begin
            rsp_stall <= 1'b1;
            phase_left = len - 1;
         end else begin
            phase_left = $urandom_range(0, 5);
         end
      end
   end

   // compare each taken result word with the oldest expected one
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bins.size() == 0) begin
            $error("result word with nothing expected: %p", rsp_word);
            mismatches++;
         end else begin
            want = pending_bins.pop_front();
            if (rsp_word.bin_index !== want.bin_index) begin
               $error("bin_index: expected %0d, got %0d", want.bin_index, rsp_word.bin_index);
               mismatches++;
            end
            if (rsp_word.opens_bin !== want.opens_bin) begin
               $error("opens_bin: expected %0d, got %0d", want.opens_bin, rsp_word.opens_bin);
               mismatches++;
            end
            if (rsp_word.pad_count !== want.pad_count) begin
               $error("pad_count: expected %0d, got %0d", want.pad_count, rsp_word.pad_count);
               mismatches++;
            end
            if (rsp_word.last_result !== want.last_result) begin
               $error("last_result: expected %0d, got %0d",
                      want.last_result, rsp_word.last_result);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long with no word moving on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
